FILE: src/row_match_counter_defines.svh
// Assertion macros shared by the row match counter checkers.
`ifndef ROW_MATCH_COUNTER_DEFINES_SVH
`define ROW_MATCH_COUNTER_DEFINES_SVH

// Same-cycle implication, reset masked.
`define RMC_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("row_match_counter: same-cycle check failed");

// Next-cycle implication, reset masked.
`define RMC_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("row_match_counter: next-cycle check failed");

`endif

FILE: src/rmc_pkg.sv
// Shared constants and types for the row match counter.
package rmc_pkg;

  localparam int ROWS      = 64;
  localparam int COLS      = 8;
  localparam int ELEM_BITS = 8;

  localparam int LANE_W     = 8;
  localparam int ROW_W      = 64;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;
  localparam int COLS_W     = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [LANE_W-1:0] ELEM_MASK = LANE_W'((1 << ELEM_BITS) - 1);

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'b1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic             clear;
    logic             valid;
    logic [IDX_W-1:0] idx;
  } scan_ctrl_t;

endpackage

FILE: src/row_match_counter.sv
// Row match counter top level: config registers, scan/emit sequencer, lanes.
//
// A load (cmd 0) writes one row into the store at the accepting edge; busy stays
// low. A query (cmd 1) reads the stored rows in use (rows_in_use, capped at 64)
// through the single store read port, one row per cycle, with eight lanes
// comparing the elements of that row at once; a flush state then finishes the
// last compare. It then walks the row indices one per cycle and puts out a beat
// for each match, stopping after the last match; a query with no match ends
// with a single no-match beat. Results cannot be stalled: each beat stands on
// the result ports for one cycle with result_valid_o high, the final one with
// last_o set, and the last beat appears in the first cycle with busy low.
module row_match_counter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                cmd_i,
  input  logic [rmc_pkg::IDX_W-1:0]           row_slot_i,
  input  logic [rmc_pkg::ROW_W-1:0]           row_value_i,
  input  logic                                cfg_we_i,
  input  logic [rmc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rmc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic                                result_valid_o,
  output logic                                found_o,
  output logic [rmc_pkg::IDX_W-1:0]           match_index_o,
  output logic [rmc_pkg::CNT_W-1:0]           match_count_o,
  output logic                                last_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]                     state_q, state_d;
  logic [rmc_pkg::CNT_W-1:0]      rows_q, rows_d;
  logic [rmc_pkg::COLS_W-1:0]     cols_q, cols_d;
  logic [rmc_pkg::CNT_W-1:0]      rows_eff;
  logic [rmc_pkg::COLS_W-1:0]     cols_eff;
  logic [rmc_pkg::ROW_W-1:0]      query_q, query_d;
  logic [rmc_pkg::IDX_W-1:0]      scan_idx_q, scan_idx_d;
  logic                           pipe_valid_q, pipe_valid_d;
  logic [rmc_pkg::IDX_W-1:0]      pipe_idx_q, pipe_idx_d;
  logic [rmc_pkg::IDX_W-1:0]      emit_idx_q, emit_idx_d;
  logic [rmc_pkg::CNT_W-1:0]      seen_q, seen_d;

  logic                           res_valid_q, res_valid_d;
  logic                           found_q, found_d;
  logic [rmc_pkg::IDX_W-1:0]      idx_q, idx_d;
  logic [rmc_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic                           last_q, last_d;

  logic                           accept;
  logic                           load_we;
  logic                           query_go;
  logic                           rd_en;
  logic [rmc_pkg::ROW_W-1:0]      rd_data;
  logic [rmc_pkg::COLS-1:0]       lane_en;
  logic [rmc_pkg::COLS-1:0]       lane_eq;
  logic [rmc_pkg::ROWS-1:0]       hit;
  logic [rmc_pkg::CNT_W-1:0]      count;
  logic [rmc_pkg::CNT_W-1:0]      seen_next;
  rmc_pkg::scan_ctrl_t            scan_ctrl;

  assign busy     = (state_q != ST_IDLE);
  assign accept   = start && !busy;
  assign query_go = accept && (cmd_i == rmc_pkg::CMD_QUERY);
  assign load_we  = accept && (cmd_i == rmc_pkg::CMD_LOAD) &&
                    ({1'b0, row_slot_i} < rmc_pkg::CNT_W'(rmc_pkg::ROWS));

  assign rows_eff = (rows_q > rmc_pkg::CNT_W'(rmc_pkg::ROWS)) ?
                    rmc_pkg::CNT_W'(rmc_pkg::ROWS) : rows_q;
  assign cols_eff = (cols_q > rmc_pkg::COLS_W'(rmc_pkg::COLS)) ?
                    rmc_pkg::COLS_W'(rmc_pkg::COLS) : cols_q;

  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        rmc_pkg::REG_ROWS_IN_USE: rows_d = cfg_data_i;
        rmc_pkg::REG_COLS_IN_USE: cols_d = cfg_data_i[rmc_pkg::COLS_W-1:0];
        default: ;
      endcase
    end
  end

  assign rd_en = (state_q == ST_SCAN);

  rmc_row_store u_store (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (row_slot_i),
    .wdata_i (row_value_i),
    .re_i    (rd_en),
    .raddr_i (scan_idx_q),
    .rdata_o (rd_data)
  );

  for (genvar g = 0; g < rmc_pkg::COLS; g++) begin : g_lane
    assign lane_en[g] = (rmc_pkg::COLS_W'(g) < cols_eff);
    rmc_lane u_lane (
      .en_i     (lane_en[g]),
      .stored_i (rd_data[g*rmc_pkg::LANE_W +: rmc_pkg::LANE_W]),
      .query_i  (query_q[g*rmc_pkg::LANE_W +: rmc_pkg::LANE_W]),
      .eq_o     (lane_eq[g])
    );
  end

  assign scan_ctrl.clear = query_go;
  assign scan_ctrl.valid = pipe_valid_q;
  assign scan_ctrl.idx   = pipe_idx_q;

  rmc_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (scan_ctrl),
    .lane_eq_i (lane_eq),
    .hit_o     (hit),
    .count_o   (count)
  );

  assign seen_next = seen_q + rmc_pkg::CNT_W'(1);

  always_comb begin
    state_d      = state_q;
    query_d      = query_q;
    scan_idx_d   = scan_idx_q;
    pipe_valid_d = (state_q == ST_SCAN);
    pipe_idx_d   = scan_idx_q;
    emit_idx_d   = emit_idx_q;
    seen_d       = seen_q;
    res_valid_d  = 1'b0;
    found_d      = found_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    last_d       = last_q;
    case (state_q)
      ST_IDLE: begin
        if (query_go) begin
          query_d    = row_value_i;
          scan_idx_d = '0;
          emit_idx_d = '0;
          seen_d     = '0;
          state_d    = (rows_eff == '0) ? ST_EMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ({1'b0, scan_idx_q} == rows_eff - rmc_pkg::CNT_W'(1)) begin
          state_d = ST_FLUSH;
        end else begin
          scan_idx_d = scan_idx_q + rmc_pkg::IDX_W'(1);
        end
      end
      ST_FLUSH: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (count == '0) begin
          res_valid_d = 1'b1;
          found_d     = 1'b0;
          idx_d       = '0;
          cnt_d       = '0;
          last_d      = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          if (hit[emit_idx_q]) begin
            res_valid_d = 1'b1;
            found_d     = 1'b1;
            idx_d       = emit_idx_q;
            cnt_d       = count;
            last_d      = (seen_next == count);
            seen_d      = seen_next;
            if (seen_next == count) begin
              state_d = ST_IDLE;
            end
          end
          emit_idx_d = emit_idx_q + rmc_pkg::IDX_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rows_q       <= rmc_pkg::CNT_W'(64);
      cols_q       <= rmc_pkg::COLS_W'(8);
      scan_idx_q   <= '0;
      pipe_valid_q <= 1'b0;
      pipe_idx_q   <= '0;
      emit_idx_q   <= '0;
      seen_q       <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      rows_q       <= rows_d;
      cols_q       <= cols_d;
      scan_idx_q   <= scan_idx_d;
      pipe_valid_q <= pipe_valid_d;
      pipe_idx_q   <= pipe_idx_d;
      emit_idx_q   <= emit_idx_d;
      seen_q       <= seen_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    query_q <= query_d;
    found_q <= found_d;
    idx_q   <= idx_d;
    cnt_q   <= cnt_d;
    last_q  <= last_d;
  end

  assign result_valid_o = res_valid_q;
  assign found_o        = found_q;
  assign match_index_o  = idx_q;
  assign match_count_o  = cnt_q;
  assign last_o         = last_q;

endmodule

FILE: src/rmc_row_store.sv
// Row store: one write port, one registered read port.
module rmc_row_store (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [rmc_pkg::IDX_W-1:0]           waddr_i,
  input  logic [rmc_pkg::ROW_W-1:0]           wdata_i,
  input  logic                                re_i,
  input  logic [rmc_pkg::IDX_W-1:0]           raddr_i,
  output logic [rmc_pkg::ROW_W-1:0]           rdata_o
);

  logic [rmc_pkg::ROW_W-1:0] mem_q [rmc_pkg::ROWS];
  logic [rmc_pkg::ROW_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/rmc_lane.sv
// One element comparator lane.
module rmc_lane (
  input  logic                        en_i,
  input  logic [rmc_pkg::LANE_W-1:0]  stored_i,
  input  logic [rmc_pkg::LANE_W-1:0]  query_i,
  output logic                        eq_o
);

  logic [rmc_pkg::LANE_W-1:0] diff;

  assign diff = (stored_i ^ query_i) & rmc_pkg::ELEM_MASK;
  assign eq_o = !en_i || (diff == '0);

endmodule

FILE: src/rmc_merge.sv
// Merges lane results into a row hit, keeps the hit vector and match count.
module rmc_merge (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rmc_pkg::scan_ctrl_t           ctrl_i,
  input  logic [rmc_pkg::COLS-1:0]      lane_eq_i,
  output logic [rmc_pkg::ROWS-1:0]      hit_o,
  output logic [rmc_pkg::CNT_W-1:0]     count_o
);

  logic                          row_hit;
  logic [rmc_pkg::ROWS-1:0]      hit_q, hit_d;
  logic [rmc_pkg::CNT_W-1:0]     count_q, count_d;

  assign row_hit = &lane_eq_i;

  always_comb begin
    hit_d   = hit_q;
    count_d = count_q;
    if (ctrl_i.clear) begin
      hit_d   = '0;
      count_d = '0;
    end else if (ctrl_i.valid && row_hit) begin
      hit_d[ctrl_i.idx] = 1'b1;
      count_d           = count_q + rmc_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q   <= '0;
      count_q <= '0;
    end else begin
      hit_q   <= hit_d;
      count_q <= count_d;
    end
  end

  assign hit_o   = hit_q;
  assign count_o = count_q;

endmodule

FILE: src/rmc_checker.sv
// Port-level checker for the row match counter, bound to the top level.
`include "row_match_counter_defines.svh"

module rmc_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  input  logic                                busy,
  input  logic                                cmd_i,
  input  logic                                result_valid_o,
  input  logic                                found_o,
  input  logic [rmc_pkg::IDX_W-1:0]           match_index_o,
  input  logic [rmc_pkg::CNT_W-1:0]           match_count_o,
  input  logic                                last_o
);

  // a no-match beat is all zero and closes the query
  `RMC_ASSERT_IMP(a_nomatch_beat, clk_i, rst_ni, result_valid_o && !found_o, last_o && (match_count_o == '0) && (match_index_o == '0))

  // a match beat carries a nonzero count
  `RMC_ASSERT_IMP(a_match_count, clk_i, rst_ni, result_valid_o && found_o, match_count_o != '0)

  // an accepted query keeps the block busy next cycle
  `RMC_ASSERT_NXT(a_query_busy, clk_i, rst_ni, start && !busy && (cmd_i == rmc_pkg::CMD_QUERY), busy)

  // a load never occupies the block
  `RMC_ASSERT_NXT(a_load_idle, clk_i, rst_ni, start && !busy && (cmd_i == rmc_pkg::CMD_LOAD), !busy)

  // beats only follow a busy cycle
  `RMC_ASSERT_IMP(a_beat_after_busy, clk_i, rst_ni, result_valid_o && $past(rst_ni), $past(busy))

endmodule

bind row_match_counter rmc_checker u_rmc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .cmd_i          (cmd_i),
  .result_valid_o (result_valid_o),
  .found_o        (found_o),
  .match_index_o  (match_index_o),
  .match_count_o  (match_count_o),
  .last_o         (last_o)
);

FILE: verif/row_match_counter_tb.sv
// Self-checking testbench for row_match_counter: row loads, queries, scoreboard.
module row_match_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT        = 200000;
  localparam int RANDOM_ITEMS = 230;
  localparam int DRAIN_CYCLES = 2 * rmc_pkg::ROWS + 4;

  typedef struct packed {
    logic                      found;
    logic [rmc_pkg::IDX_W-1:0] idx;
    logic [rmc_pkg::CNT_W-1:0] count;
    logic                      last;
  } match_beat_t;

  class match_scoreboard;
    logic [rmc_pkg::ROW_W-1:0]  row_store [rmc_pkg::ROWS];
    bit                         written [rmc_pkg::ROWS];
    logic [rmc_pkg::CNT_W-1:0]  rows_reg;
    logic [rmc_pkg::COLS_W-1:0] cols_reg;
    match_beat_t                pending_q [$];
    int                         errors;

    function new();
      rows_reg = rmc_pkg::CNT_W'(rmc_pkg::ROWS);
      cols_reg = rmc_pkg::COLS_W'(rmc_pkg::COLS);
      errors   = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function void write_reg(logic [rmc_pkg::CFG_IDX_W-1:0] idx,
                            logic [rmc_pkg::CFG_DATA_W-1:0] data);
      if (idx == rmc_pkg::REG_ROWS_IN_USE) begin
        rows_reg = data;
      end else if (idx == rmc_pkg::REG_COLS_IN_USE) begin
        cols_reg = data[rmc_pkg::COLS_W-1:0];
      end
    endfunction

    function int rows_eff();
      return (rows_reg > rmc_pkg::ROWS) ? rmc_pkg::ROWS : int'(rows_reg);
    endfunction

    function logic [rmc_pkg::ROW_W-1:0] lane_mask();
      int                        cols;
      logic [rmc_pkg::ROW_W-1:0] m;
      cols = (cols_reg > rmc_pkg::COLS) ? rmc_pkg::COLS : int'(cols_reg);
      m = '0;
      for (int j = 0; j < cols; j++)
        m |= rmc_pkg::ROW_W'(rmc_pkg::ELEM_MASK) << (rmc_pkg::LANE_W * j);
      return m;
    endfunction

    function int first_unwritten();
      for (int i = 0; i < rmc_pkg::ROWS; i++) if (!written[i]) return i;
      return rmc_pkg::ROWS;
    endfunction

    // Predict the beats of one accepted command.
    function void note_beat(logic cmd, logic [rmc_pkg::IDX_W-1:0] slot,
                            logic [rmc_pkg::ROW_W-1:0] value);
      logic [rmc_pkg::ROW_W-1:0] m;
      int                        rows;
      int                        count;
      int                        n;
      match_beat_t               b;
      if (cmd == rmc_pkg::CMD_LOAD) begin
        row_store[slot] = value;
        written[slot]   = 1'b1;
        return;
      end
      rows  = rows_eff();
      m     = lane_mask();
      count = 0;
      for (int i = 0; i < rows; i++) if (((row_store[i] ^ value) & m) == '0) count++;
      if (count == 0) begin
        b = '{found: 1'b0, idx: '0, count: '0, last: 1'b1};
        pending_q.push_back(b);
        return;
      end
      n = 0;
      for (int i = 0; i < rows; i++) begin
        if (((row_store[i] ^ value) & m) == '0) begin
          n++;
          b.found = 1'b1;
          b.idx   = rmc_pkg::IDX_W'(i);
          b.count = rmc_pkg::CNT_W'(count);
          b.last  = (n == count);
          pending_q.push_back(b);
        end
      end
    endfunction

    task report(string msg);
      $display("%0t ERROR: %s", $time, msg);
      errors++;
    endtask

    task check_result(match_beat_t got);
      match_beat_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected beat found=%0d idx=%0d count=%0d last=%0d",
                         got.found, got.idx, got.count, got.last));
        return;
      end
      want = pending_q.pop_front();
      if (got.found !== want.found)
        report($sformatf("found_o got %0d want %0d", got.found, want.found));
      if (got.idx !== want.idx)
        report($sformatf("match_index_o got %0d want %0d", got.idx, want.idx));
      if (got.count !== want.count)
        report($sformatf("match_count_o got %0d want %0d", got.count, want.count));
      if (got.last !== want.last)
        report($sformatf("last_o got %0d want %0d", got.last, want.last));
    endtask
  endclass

  logic                             clk_i       = 1'b0;
  logic                             rst_ni      = 1'b0;
  logic                             start       = 1'b0;
  logic                             busy;
  logic                             cmd_i       = rmc_pkg::CMD_LOAD;
  logic [rmc_pkg::IDX_W-1:0]        row_slot_i  = '0;
  logic [rmc_pkg::ROW_W-1:0]        row_value_i = '0;
  logic                             cfg_we_i    = 1'b0;
  logic [rmc_pkg::CFG_IDX_W-1:0]    cfg_idx_i   = rmc_pkg::REG_ROWS_IN_USE;
  logic [rmc_pkg::CFG_DATA_W-1:0]   cfg_data_i  = '0;
  logic                             result_valid_o;
  logic                             found_o;
  logic [rmc_pkg::IDX_W-1:0]        match_index_o;
  logic [rmc_pkg::CNT_W-1:0]        match_count_o;
  logic                             last_o;

  match_scoreboard sb;
  int unsigned     cycles = 0;

  row_match_counter DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .row_slot_i     (row_slot_i),
    .row_value_i    (row_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .found_o        (found_o),
    .match_index_o  (match_index_o),
    .match_count_o  (match_count_o),
    .last_o         (last_o)
  );

  always #5ns clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sb.check_result('{found: found_o, idx: match_index_o, count: match_count_o,
                        last: last_o});
    end
  end

  function automatic logic [rmc_pkg::ROW_W-1:0] rand_row();
    return {$urandom, $urandom};
  endfunction

  // One command beat; start stays high on return so back-to-back beats need no gap.
  task automatic drive_beat(logic cmd, logic [rmc_pkg::IDX_W-1:0] slot,
                            logic [rmc_pkg::ROW_W-1:0] value, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    cmd_i       <= cmd;
    row_slot_i  <= slot;
    row_value_i <= value;
    do @(posedge clk_i); while (busy);
    sb.note_beat(cmd, slot, value);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (sb.pending_q.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_config(logic [rmc_pkg::CFG_DATA_W-1:0] rows,
                            logic [rmc_pkg::CFG_DATA_W-1:0] cols);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= rmc_pkg::REG_ROWS_IN_USE;
    cfg_data_i <= rows;
    @(posedge clk_i);
    sb.write_reg(rmc_pkg::REG_ROWS_IN_USE, rows);
    cfg_idx_i  <= rmc_pkg::REG_COLS_IN_USE;
    cfg_data_i <= cols;
    @(posedge clk_i);
    sb.write_reg(rmc_pkg::REG_COLS_IN_USE, cols);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    int                             total;
    int                             phase;
    int                             phase_len;
    int                             done;
    int                             rows_now;
    int                             r;
    int                             k;
    logic [rmc_pkg::CFG_DATA_W-1:0] rows_cfg;
    logic [rmc_pkg::CFG_DATA_W-1:0] cols_cfg;
    logic [rmc_pkg::ROW_W-1:0]      pool [3];
    logic [rmc_pkg::ROW_W-1:0]      v;
    logic [rmc_pkg::ROW_W-1:0]      m;
    logic [rmc_pkg::IDX_W-1:0]      slot;
    bit                             no_gap;

    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, duplicates, no match, zero rows, zero/over-range columns
    set_config(7'd3, 7'd8);
    drive_beat(rmc_pkg::CMD_LOAD, 6'd0, '0, 1'b0);
    drive_beat(rmc_pkg::CMD_LOAD, 6'd1, '1, 1'b1);
    drive_beat(rmc_pkg::CMD_LOAD, 6'd2, '0, 1'b0);
    drive_beat(rmc_pkg::CMD_QUERY, 6'h15, '0, 1'b0);
    drive_beat(rmc_pkg::CMD_QUERY, 6'h3F, '1, 1'b1);
    drive_beat(rmc_pkg::CMD_QUERY, 6'h2A, 64'h0807_0605_0403_0201, 1'b0);
    set_config(7'd3, 7'd0);
    drive_beat(rmc_pkg::CMD_QUERY, 6'd0, rand_row(), 1'b0);
    set_config(7'd3, 7'd1);
    drive_beat(rmc_pkg::CMD_QUERY, 6'd0,
               rand_row() & ~rmc_pkg::ROW_W'(rmc_pkg::ELEM_MASK), 1'b0);
    set_config(7'd3, 7'd15);
    drive_beat(rmc_pkg::CMD_QUERY, 6'd0, '1, 1'b0);
    set_config(7'd0, 7'd8);
    drive_beat(rmc_pkg::CMD_QUERY, 6'd0, '0, 1'b0);
    set_config(7'd1, 7'd8);
    drive_beat(rmc_pkg::CMD_QUERY, 6'd0, '0, 1'b0);
    drive_beat(rmc_pkg::CMD_LOAD, 6'h3F, 64'hA5A5_A5A5_A5A5_A5A5, 1'b1);
    drive_beat(rmc_pkg::CMD_LOAD, 6'h2A, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0);

    // random phases: each picks a setting, a small pattern pool, and a gap style
    total = 0;
    phase = 0;
    while (total < RANDOM_ITEMS) begin
      case (phase)
        0: begin rows_cfg = 7'd64;  cols_cfg = 7'd8;  end
        1: begin rows_cfg = 7'd127; cols_cfg = 7'd1;  end
        2: begin rows_cfg = 7'd1;   cols_cfg = 7'd15; end
        3: begin rows_cfg = 7'd0;   cols_cfg = 7'd0;  end
        default: begin
          rows_cfg = rmc_pkg::CFG_DATA_W'($urandom_range(1, 127));
          cols_cfg = rmc_pkg::CFG_DATA_W'($urandom_range(0, 15));
        end
      endcase
      set_config(rows_cfg, cols_cfg);
      pool[0]   = rand_row();
      pool[1]   = pool[0] ^ (rmc_pkg::ROW_W'($urandom_range(1, 255))
                             << (rmc_pkg::LANE_W * $urandom_range(0, 7)));
      pool[2]   = rand_row();
      no_gap    = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 40);
      rows_now  = sb.rows_eff();
      m         = sb.lane_mask();
      done      = 0;
      while (done < phase_len) begin
        k = $urandom_range(0, 2);
        if (sb.first_unwritten() < rows_now) begin
          drive_beat(rmc_pkg::CMD_LOAD, rmc_pkg::IDX_W'(sb.first_unwritten()), pool[k],
                     no_gap);
        end else begin
          r = $urandom_range(0, 99);
          if (r < 40) begin
            v = pool[k];
            if ($urandom_range(0, 2) == 0)
              v ^= rmc_pkg::ROW_W'($urandom_range(1, 255))
                   << (rmc_pkg::LANE_W * $urandom_range(0, 7));
            else if ($urandom_range(0, 9) == 0)
              v = rand_row();
            if (rows_now > 0 && $urandom_range(0, 3) != 0)
              slot = rmc_pkg::IDX_W'($urandom_range(0, rows_now - 1));
            else
              slot = rmc_pkg::IDX_W'($urandom_range(0, rmc_pkg::ROWS - 1));
            drive_beat(rmc_pkg::CMD_LOAD, slot, v, no_gap);
          end else if (r < 90) begin
            drive_beat(rmc_pkg::CMD_QUERY, rmc_pkg::IDX_W'($urandom),
                       (pool[k] & m) | (rand_row() & ~m), no_gap);
          end else begin
            drive_beat(rmc_pkg::CMD_QUERY, rmc_pkg::IDX_W'($urandom), rand_row(), no_gap);
          end
          done++;
        end
        total++;
      end
      phase++;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/rmc_pkg.sv
src/rmc_row_store.sv
src/rmc_lane.sv
src/rmc_merge.sv
src/row_match_counter.sv
src/rmc_checker.sv
verif/row_match_counter_tb.sv
